>>> rtl/core/flapping_wing_actuator_mixer_top_macros.svh
// ---------------------------------------------------------------------------
// actuator mixer assertion macros
// shared concurrent assertion wrappers for the mixer checker
// ---------------------------------------------------------------------------
`ifndef FLAPPING_WING_ACTUATOR_MIXER_TOP_MACROS_SVH
`define FLAPPING_WING_ACTUATOR_MIXER_TOP_MACROS_SVH

// property checked only outside reset
`define FWAM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define FWAM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/fwam_pkg.sv
// ---------------------------------------------------------------------------
// fwam_pkg
// types and constants shared by the actuator mixer modules
// ---------------------------------------------------------------------------
package fwam_pkg;

   localparam int CmdW   = 16;
   localparam int ValW   = 16;
   localparam int PctW   = 8;
   localparam int CsrIdW = 3;
   localparam int CsrDW  = 16;

   // mix numerators are value*100, signed, worst case about 16.7M
   localparam int NumW = 26;
   // below the saturation limit a numerator fits this many bits
   localparam int DivW = 23;

   localparam int FullScale = 65535;
   localparam int NeutralLo = 25;
   localparam int NeutralHi = 75;

   // n / 100 as (n * ceil(2^30 / 100)) >> 30, exact for n < 2^23
   localparam int RecipShift = 30;
   localparam int RecipW     = 24;
   localparam logic [RecipW-1:0] RecipK = RecipW'(((64'd1 << RecipShift) + 64'd99) / 64'd100);
   localparam int ProdW      = DivW + RecipW;
   localparam logic signed [NumW-1:0] SatLimit = NumW'(FullScale * 100);

   localparam logic [PctW-1:0]  PitchNeutralRst  = 8'd50;
   localparam logic [PctW-1:0]  YawNeutralRst    = 8'd50;
   localparam logic [PctW-1:0]  GripOpenRst      = 8'd75;
   localparam logic [PctW-1:0]  GripClosedRst    = 8'd25;
   localparam logic [PctW-1:0]  GripForceRst     = 8'd0;
   localparam logic [PctW-1:0]  RollBiasRst      = 8'd0;
   localparam logic [ValW-1:0]  ThrustCapRst     = 16'd60000;
   localparam logic [ValW-1:0]  IdleFloorRst     = 16'd0;

   typedef enum logic [CsrIdW-1:0] {
      RegPitchNeutral  = 3'd0,
      RegYawNeutral    = 3'd1,
      RegGripOpenPos   = 3'd2,
      RegGripClosedPos = 3'd3,
      RegGripForceOn   = 3'd4,
      RegRollBias      = 3'd5,
      RegThrustCap     = 3'd6,
      RegIdleFloor     = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [ValW-1:0] gripper_servo_out;
      logic [ValW-1:0] right_motor_out;
      logic [ValW-1:0] left_motor_out;
      logic [ValW-1:0] yaw_servo_out;
      logic [ValW-1:0] pitch_servo_out;
   } rsp_data_type;

   typedef struct packed {
      logic signed [CmdW-1:0] yaw_cmd;
      logic signed [CmdW-1:0] pitch_cmd;
      logic signed [CmdW-1:0] roll_cmd;
      logic        [CmdW-1:0] thrust_cmd;
   } req_data_type;

   function automatic logic [PctW-1:0] clamp_neutral(input logic [PctW-1:0] v);
      logic [PctW-1:0] r;
      if (v > PctW'(NeutralHi)) begin
         r = PctW'(NeutralHi);
      end else if (v < PctW'(NeutralLo)) begin
         r = PctW'(NeutralLo);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/flapping_wing_actuator_mixer_top.sv
// ---------------------------------------------------------------------------
// flapping_wing_actuator_mixer_top
// two-motor wing actuator mixer with pitch, yaw and gripper servos
// ---------------------------------------------------------------------------
// Takes one command word per clock while req_tready is high and returns one
// word of five actuator values per command, in order. The path is a
// four-register pipeline: input register, mix register (thrust cap and the
// bias multiply), reciprocal product register (the divide by 100 of each
// value) and the output register; each stage moves on when the one after it
// is empty or moving, so rsp_tready back pressure reaches req_tready in the
// same cycle. Configuration is taken on any cycle and should only be written
// while no command is in flight.
module flapping_wing_actuator_mixer_top (
   input  logic                          clock,
   input  logic                          reset,
   // thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd
   input  logic [4*fwam_pkg::CmdW-1:0]   req_tdata,
   // grip_switch
   input  logic                          req_tuser,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pitch_servo_out, yaw_servo_out, left_motor_out, right_motor_out,
   // gripper_servo_out
   output logic [5*fwam_pkg::ValW-1:0]   rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fwam_pkg::CsrIdW-1:0]   csr_index,
   input  logic [fwam_pkg::CsrDW-1:0]    csr_data
);

   localparam int NumW = fwam_pkg::NumW;
   localparam int PctW = fwam_pkg::PctW;
   localparam int ValW = fwam_pkg::ValW;

   // configuration registers
   logic [PctW-1:0] pitch_neutral_ff, yaw_neutral_ff, grip_open_ff, grip_closed_ff;
   logic [PctW-1:0] grip_force_ff, roll_bias_ff;
   logic [ValW-1:0] thrust_cap_ff, idle_floor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_neutral_ff <= fwam_pkg::PitchNeutralRst;
         yaw_neutral_ff   <= fwam_pkg::YawNeutralRst;
         grip_open_ff     <= fwam_pkg::GripOpenRst;
         grip_closed_ff   <= fwam_pkg::GripClosedRst;
         grip_force_ff    <= fwam_pkg::GripForceRst;
         roll_bias_ff     <= fwam_pkg::RollBiasRst;
         thrust_cap_ff    <= fwam_pkg::ThrustCapRst;
         idle_floor_ff    <= fwam_pkg::IdleFloorRst;
      end else if (csr_valid && csr_ready) begin
         case (fwam_pkg::csr_reg_type'(csr_index))
            fwam_pkg::RegPitchNeutral:  pitch_neutral_ff <= csr_data[PctW-1:0];
            fwam_pkg::RegYawNeutral:    yaw_neutral_ff   <= csr_data[PctW-1:0];
            fwam_pkg::RegGripOpenPos:   grip_open_ff     <= csr_data[PctW-1:0];
            fwam_pkg::RegGripClosedPos: grip_closed_ff   <= csr_data[PctW-1:0];
            fwam_pkg::RegGripForceOn:   grip_force_ff    <= csr_data[PctW-1:0];
            fwam_pkg::RegRollBias:      roll_bias_ff     <= csr_data[PctW-1:0];
            fwam_pkg::RegThrustCap:     thrust_cap_ff    <= csr_data[ValW-1:0];
            fwam_pkg::RegIdleFloor:     idle_floor_ff    <= csr_data[ValW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic in_vld_ff, mix_vld_ff, div_vld_ff, out_vld_ff;
   logic in_rdy, mix_rdy, div_rdy, out_rdy;

   assign out_rdy    = !out_vld_ff || rsp_tready;
   assign div_rdy    = !div_vld_ff || out_rdy;
   assign mix_rdy    = !mix_vld_ff || div_rdy;
   assign in_rdy     = !in_vld_ff  || mix_rdy;
   assign req_tready = in_rdy;
   assign rsp_tvalid = out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mix_vld_ff <= 1'b0;
         div_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_rdy)  in_vld_ff  <= req_tvalid;
         if (mix_rdy) mix_vld_ff <= in_vld_ff;
         if (div_rdy) div_vld_ff <= mix_vld_ff;
         if (out_rdy) out_vld_ff <= div_vld_ff;
      end
   end

   // input register
   fwam_pkg::req_data_type req_ff;
   logic                   grip_sw_ff;

   always_ff @(posedge clock) begin
      if (in_rdy) begin
         req_ff     <= fwam_pkg::req_data_type'(req_tdata);
         grip_sw_ff <= req_tuser;
      end
   end

   // mix stage: every value as value*100
   logic        [ValW-1:0] thrust_lim;
   logic signed [8:0]      w_left, w_right;
   logic        [PctW-1:0] pn, yn, grip_pct;
   logic signed [NumW-1:0] roll_x, pitch_x, yaw_x, thrust_x;
   logic signed [NumW-1:0] pitch_n_in, yaw_n_in, left_n_in, right_n_in, grip_n_in;
   logic signed [NumW-1:0] pitch_n_ff, yaw_n_ff, left_n_ff, right_n_ff, grip_n_ff;

   always_comb begin
      thrust_lim = (req_ff.thrust_cmd > thrust_cap_ff) ? thrust_cap_ff : req_ff.thrust_cmd;
      w_left     = 9'sd100 + 9'(signed'(roll_bias_ff));
      w_right    = 9'sd100 - 9'(signed'(roll_bias_ff));
      pn         = fwam_pkg::clamp_neutral(pitch_neutral_ff);
      yn         = fwam_pkg::clamp_neutral(yaw_neutral_ff);
      grip_pct   = (grip_sw_ff || (grip_force_ff != '0)) ? grip_open_ff : grip_closed_ff;
      roll_x     = NumW'(req_ff.roll_cmd);
      pitch_x    = NumW'(req_ff.pitch_cmd);
      yaw_x      = NumW'(req_ff.yaw_cmd);
      thrust_x   = signed'(NumW'(thrust_lim));
      left_n_in  = roll_x * NumW'(50) + thrust_x * NumW'(w_left);
      right_n_in = thrust_x * NumW'(w_right) - roll_x * NumW'(50);
      pitch_n_in = signed'(NumW'(pn)) * NumW'(fwam_pkg::FullScale) + pitch_x * NumW'(40);
      yaw_n_in   = signed'(NumW'(yn)) * NumW'(fwam_pkg::FullScale) - yaw_x * NumW'(100);
      grip_n_in  = signed'(NumW'(grip_pct)) * NumW'(fwam_pkg::FullScale);
   end

   always_ff @(posedge clock) begin
      if (mix_rdy) begin
         pitch_n_ff <= pitch_n_in;
         yaw_n_ff   <= yaw_n_in;
         left_n_ff  <= left_n_in;
         right_n_ff <= right_n_in;
         grip_n_ff  <= grip_n_in;
      end
   end

   // divide stage, one settle lane per value
   logic [ValW-1:0] pitch_v, yaw_v, left_v, right_v, grip_v;

   fwam_settle u_settle_pitch (.clock(clock), .load(div_rdy), .num(pitch_n_ff), .value(pitch_v));
   fwam_settle u_settle_yaw   (.clock(clock), .load(div_rdy), .num(yaw_n_ff),   .value(yaw_v));
   fwam_settle u_settle_left  (.clock(clock), .load(div_rdy), .num(left_n_ff),  .value(left_v));
   fwam_settle u_settle_right (.clock(clock), .load(div_rdy), .num(right_n_ff), .value(right_v));
   fwam_settle u_settle_grip  (.clock(clock), .load(div_rdy), .num(grip_n_ff),  .value(grip_v));

   // output register, motors held at or above the idle floor
   fwam_pkg::rsp_data_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.pitch_servo_out   = pitch_v;
      rsp_in.yaw_servo_out     = yaw_v;
      rsp_in.left_motor_out    = (left_v < idle_floor_ff) ? idle_floor_ff : left_v;
      rsp_in.right_motor_out   = (right_v < idle_floor_ff) ? idle_floor_ff : right_v;
      rsp_in.gripper_servo_out = grip_v;
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

>>> rtl/core/fwam_settle.sv
// ---------------------------------------------------------------------------
// fwam_settle
// turns a value*100 numerator into a 16-bit value: truncate, clamp 0..65535
// ---------------------------------------------------------------------------
module fwam_settle (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [fwam_pkg::NumW-1:0]    num,
   output logic        [fwam_pkg::ValW-1:0]    value
);

   logic                          zero_ff, zero_in;
   logic                          sat_ff, sat_in;
   logic [fwam_pkg::ProdW-1:0]    prod_ff, prod_in;

   always_comb begin
      // negative or zero numerator settles to zero
      zero_in = num[fwam_pkg::NumW-1] || (num == '0);
      sat_in  = (num >= fwam_pkg::SatLimit);
      // only meaningful when neither flag is set, then num is below 2^23
      prod_in = fwam_pkg::ProdW'(num[fwam_pkg::DivW-1:0]) *
                fwam_pkg::ProdW'(fwam_pkg::RecipK);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         zero_ff <= zero_in;
         sat_ff  <= sat_in;
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      if (zero_ff) begin
         value = '0;
      end else if (sat_ff) begin
         value = '1;
      end else begin
         value = prod_ff[fwam_pkg::RecipShift +: fwam_pkg::ValW];
      end
   end

endmodule

>>> rtl/core/fwam_checker.sv
// ---------------------------------------------------------------------------
// fwam_checker
// port-level checks on the actuator mixer, bound to the top level
// ---------------------------------------------------------------------------
`include "flapping_wing_actuator_mixer_top_macros.svh"

module fwam_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tready,
   input  logic [5*fwam_pkg::ValW-1:0]   rsp_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_ready
);

   // a stalled result word stays put
   `FWAM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // a draining output never blocks the input side
   `FWAM_ASSERT(a_ready_flow, clock, reset, rsp_tready |-> req_tready, "req_tready low while rsp_tready high")

   // nothing comes out right after reset
   `FWAM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")

   // the register port never back-pressures
   `FWAM_ASSERT(a_csr_ready, clock, reset, csr_ready, "csr_ready low")

endmodule

bind flapping_wing_actuator_mixer_top fwam_checker u_fwam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_ready  (csr_ready)
);
